[design/bsfr_pkg.sv]
// ----------------------------------------------------------------------------
// bsfr_pkg
// Shared types, constants and the CRC-8 step for the byte-stuffed frame
// receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  // Framing bytes.
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_LO    = 8'h5D;
  localparam logic [7:0] ESC_HI    = 8'h5E;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // CRC-8, polynomial x^8 + x^2 + x + 1.
  localparam logic [7:0] CRC_POLY  = 8'h07;

  // Frame layout: nine header bytes, payload, one CRC byte.
  localparam int HDR_LEN        = 9;
  localparam int FRAME_OVERHEAD = 10;

  // Default sizes.
  localparam int PAYLOAD_DEPTH_DEF = 16;
  localparam int RAW_DEPTH_DEF     = 26;

  // Register reset values.
  localparam logic [15:0] TIMEOUT_RST = 16'd100;
  localparam logic [7:0]  VERSION_RST = 8'd1;
  localparam logic [4:0]  MAXPAY_RST  = 5'd16;

  // Register indexes (byte address / 4).
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_MAXPAY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  command;
    logic [4:0]  length;
    logic [15:0] sequence_res;
    logic [31:0] session;
    logic [7:0]  payload_byte;
    logic [3:0]  payload_index;
    logic        payload_valid;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [7:0]  expected_version;
    logic [4:0]  max_payload;
  } cfg_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[design/bsfr_ram.sv]
// ----------------------------------------------------------------------------
// bsfr_ram
// Frame buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsfr_ram #(
  parameter int DEPTH = bsfr_pkg::RAW_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[design/bsfr_core.sv]
// ----------------------------------------------------------------------------
// bsfr_core
// Deframing sequencer: per-byte unstuffing and CRC, frame checks at the
// closing flag, payload read-out from the frame buffer, output register.
// ----------------------------------------------------------------------------
module bsfr_core #(
  parameter int PAYLOAD_DEPTH = bsfr_pkg::PAYLOAD_DEPTH_DEF,
  parameter int RAW_DEPTH     = bsfr_pkg::RAW_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsfr_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bsfr_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bsfr_pkg::out_t               out_data,
  output logic                         mem_wr_en,
  output logic [$clog2(RAW_DEPTH)-1:0] mem_wr_addr,
  output logic [7:0]                   mem_wr_data,
  output logic [$clog2(RAW_DEPTH)-1:0] mem_rd_addr,
  input  logic [7:0]                   mem_rd_data
);
  import bsfr_pkg::*;

  localparam int CW = $clog2(RAW_DEPTH + 1);
  localparam int AW = $clog2(RAW_DEPTH);
  localparam int KW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [7:0] PD8 = 8'(PAYLOAD_DEPTH);

  state_t          state_r, state_nxt;
  logic            in_frame_r, in_frame_nxt;
  logic            esc_r, esc_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [7:0]      crc_r, crc_nxt;
  logic [7:0]      cbl_r, cbl_nxt;
  logic [31:0]     last_arr_r;
  logic            tmo_r;
  logic [7:0]      byte_r;
  logic [7:0]      hdr_r [HDR_LEN];
  logic [7:0]      hdr_nxt [HDR_LEN];
  logic [7:0]      lastb_r, lastb_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_r, out_nxt;

  logic            accept;
  logic            slot_free;
  logic [31:0]     delta;
  logic            f_in, f_esc;
  logic [CW-1:0]   f_cnt;
  logic [7:0]      f_crc;
  logic [7:0]      b;
  logic [7:0]      mp8, lim8;
  logic            frame_ok;
  logic            do_store;
  out_t            rej, hdr_out;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign slot_free = !out_valid_r || !out_stall;
  assign delta     = in_data.now_ms - last_arr_r;

  // A timed-out frame is treated as dropped before the byte is handled.
  assign f_in  = in_frame_r && !tmo_r;
  assign f_esc = esc_r && !tmo_r;
  assign f_cnt = tmo_r ? '0 : cnt_r;
  assign f_crc = tmo_r ? 8'h00 : crc_r;

  assign mp8  = {3'b000, cfg.max_payload};
  assign lim8 = (mp8 < PD8) ? mp8 : PD8;

  assign frame_ok = !f_esc
                 && (f_cnt >= CW'(FRAME_OVERHEAD))
                 && (hdr_r[0] == cfg.expected_version)
                 && (hdr_r[2] <= lim8)
                 && (({1'b0, hdr_r[2]} + 9'(FRAME_OVERHEAD)) == 9'(f_cnt))
                 && (cbl_r == lastb_r);

  always_comb begin
    rej        = '0;
    rej.status = 1'b1;
    rej.last   = 1'b1;
    hdr_out              = '0;
    hdr_out.command      = hdr_r[1];
    hdr_out.length       = hdr_r[2][4:0];
    hdr_out.sequence_res = {hdr_r[4], hdr_r[3]};
    hdr_out.session      = {hdr_r[8], hdr_r[7], hdr_r[6], hdr_r[5]};
  end

  always_comb begin
    state_nxt     = state_r;
    in_frame_nxt  = in_frame_r;
    esc_nxt       = esc_r;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    cbl_nxt       = cbl_r;
    hdr_nxt       = hdr_r;
    lastb_nxt     = lastb_r;
    k_nxt         = k_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_wr_en     = 1'b0;
    b             = byte_r;
    do_store      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_PROC;
        end
      end

      ST_PROC: begin
        state_nxt    = ST_IDLE;
        in_frame_nxt = f_in;
        esc_nxt      = f_esc;
        cnt_nxt      = f_cnt;
        crc_nxt      = f_crc;
        cbl_nxt      = tmo_r ? 8'h00 : cbl_r;
        k_nxt        = '0;
        if (byte_r == FLAG_BYTE) begin
          if (f_in && (f_cnt != '0)) begin
            out_valid_nxt = 1'b1;
            if (!frame_ok) begin
              out_nxt = rej;
            end else if (hdr_r[2] == 8'h00) begin
              out_nxt      = hdr_out;
              out_nxt.last = 1'b1;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = ST_EMIT;
            end
          end
          in_frame_nxt = 1'b1;
          esc_nxt      = 1'b0;
          cnt_nxt      = '0;
          crc_nxt      = 8'h00;
          cbl_nxt      = 8'h00;
        end else if (f_in) begin
          if (f_esc) begin
            if ((byte_r != ESC_LO) && (byte_r != ESC_HI)) begin
              out_valid_nxt = 1'b1;
              out_nxt       = rej;
              in_frame_nxt  = 1'b0;
              esc_nxt       = 1'b0;
              cnt_nxt       = '0;
              crc_nxt       = 8'h00;
              cbl_nxt       = 8'h00;
            end else begin
              b        = byte_r ^ ESC_XOR;
              esc_nxt  = 1'b0;
              do_store = 1'b1;
            end
          end else if (byte_r == ESC_BYTE) begin
            esc_nxt = 1'b1;
          end else begin
            do_store = 1'b1;
          end
          if (do_store) begin
            if (f_cnt >= CW'(RAW_DEPTH)) begin
              out_valid_nxt = 1'b1;
              out_nxt       = rej;
              in_frame_nxt  = 1'b0;
              esc_nxt       = 1'b0;
              cnt_nxt       = '0;
              crc_nxt       = 8'h00;
              cbl_nxt       = 8'h00;
            end else begin
              mem_wr_en = 1'b1;
              for (int i = 0; i < HDR_LEN; i++) begin
                if (f_cnt == CW'(i)) begin
                  hdr_nxt[i] = b;
                end
              end
              lastb_nxt = b;
              cnt_nxt   = f_cnt + CW'(1);
              cbl_nxt   = f_crc;
              crc_nxt   = crc8_update(f_crc, b);
            end
          end
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt               = hdr_out;
          out_nxt.payload_byte  = mem_rd_data;
          out_nxt.payload_index = 4'(k_r);
          out_nxt.payload_valid = 1'b1;
          out_nxt.last          = ((8'(k_r) + 8'd1) == hdr_r[2]);
          if (out_nxt.last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + KW'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign mem_wr_addr = f_cnt[AW-1:0];
  assign mem_wr_data = b;
  // The read runs every cycle, so the entry for the next beat is ready when
  // the output slot frees up.
  assign mem_rd_addr = AW'(HDR_LEN) + AW'(k_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_frame_r  <= 1'b0;
      esc_r       <= 1'b0;
      cnt_r       <= '0;
      crc_r       <= 8'h00;
      cbl_r       <= 8'h00;
      last_arr_r  <= '0;
      tmo_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_frame_r  <= in_frame_nxt;
      esc_r       <= esc_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      cbl_r       <= cbl_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        last_arr_r <= in_data.now_ms;
        tmo_r      <= in_frame_r && (delta > {16'h0000, cfg.timeout_ms});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_data.rx_byte;
    end
    hdr_r   <= hdr_nxt;
    lastb_r <= lastb_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[design/byte_stuffed_frame_receiver.sv]
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver
// Byte-stuffed frame receiver with CRC-8 check and timeout-based resync.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one wire byte and its arrival time in ms.
// The 0x7E flag opens and closes frames and 0x7D escapes the following byte.
// At a closing flag the frame is checked (version, length, size, CRC-8) and a
// good frame leaves as a run of result beats, one per payload byte, each with
// the header fields; an empty payload gives one beat. Any failure gives a
// single reject beat. A gap longer than timeout_ms drops a partial frame.
// Sequencing: each input byte is accepted in ST_IDLE, then unstuffed, stored
// and folded into the CRC in ST_PROC; no new byte is taken until then. A
// closing flag of a good frame then reads the payload from the frame buffer
// in ST_EMIT, one beat per payload byte, holding while out_stall is high.
// Each result beat is registered in the output register before it leaves.
// in_stall is high while a byte or a frame read-out is in progress, and
// while an unconsumed result waits in the output register under out_stall.
// Reset clears the frame state and loads the register defaults; the frame
// buffer itself is not cleared, since only bytes of the current frame are
// ever read back.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver #(
  parameter int PAYLOAD_DEPTH = bsfr_pkg::PAYLOAD_DEPTH_DEF,
  parameter int RAW_DEPTH     = bsfr_pkg::RAW_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  // Input channel.
  input  logic           in_valid,
  output logic           in_stall,
  input  bsfr_pkg::in_t  in_data,
  // Result channel.
  output logic           out_valid,
  input  logic           out_stall,
  output bsfr_pkg::out_t out_data,
  // Configuration port.
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import bsfr_pkg::*;

  localparam int AW = $clog2(RAW_DEPTH);

  cfg_t          cfg_r;
  logic          cfg_wr;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;

  // Register file. Writes land in the access phase; reads are combinational.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms       <= TIMEOUT_RST;
      cfg_r.expected_version <= VERSION_RST;
      cfg_r.max_payload      <= MAXPAY_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TIMEOUT: cfg_r.timeout_ms       <= pwdata[15:0];
        REG_VERSION: cfg_r.expected_version <= pwdata[7:0];
        REG_MAXPAY:  cfg_r.max_payload      <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TIMEOUT: prdata = {16'h0000, cfg_r.timeout_ms};
      REG_VERSION: prdata = {24'h000000, cfg_r.expected_version};
      REG_MAXPAY:  prdata = {27'h0000000, cfg_r.max_payload};
      default:     prdata = 32'h00000000;
    endcase
  end

  // Deframing sequencer.
  bsfr_core #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
    .RAW_DEPTH     (RAW_DEPTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // Frame buffer holding the unstuffed bytes of the current frame.
  bsfr_ram #(
    .DEPTH (RAW_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

`ifndef SYNTHESIS
  // Every accepted byte occupies the block for its processing cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in consecutive cycles");

  // A reject beat is always a lone, data-free final beat.
  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.last && !out_data.payload_valid)
    else $error("malformed reject beat");

  // A beat without payload data must end its run.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.payload_valid |-> out_data.last)
    else $error("data-free beat that does not end its run");
`endif

endmodule

[test/byte_stuffed_frame_receiver_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_checker
// Watches the byte, result and register ports of the frame receiver, works
// out the result beats that every accepted byte must cause and compares them
// in order with the beats that leave the block.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  bsfr_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  bsfr_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic           pready,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output int unsigned    mismatches,
  output int unsigned    beats_owed
);
  import bsfr_pkg::*;

  localparam int unsigned RAW = RAW_DEPTH_DEF;
  localparam int unsigned PAY = PAYLOAD_DEPTH_DEF;

  // Mirror of the receiver's frame state and registers.
  logic [7:0]  frame_mem [RAW];
  int unsigned fill;
  logic        esc_armed;
  logic        framing;
  logic [31:0] last_ms;
  logic [7:0]  crc_run;
  logic [7:0]  crc_prev;
  logic [15:0] timeout_cfg;
  logic [7:0]  version_cfg;
  logic [4:0]  max_pay_cfg;

  out_t        owed_q[$];
  int unsigned err_cnt = 0;

  // CRC-8 folded one bit at a time, most significant bit first.
  function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ d[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  function automatic string beat_text(input out_t r);
    return $sformatf("st=%0d cmd=%02h len=%0d seq=%04h ses=%08h byte=%02h idx=%0d dv=%0d last=%0d",
                     r.status, r.command, r.length, r.sequence_res, r.session,
                     r.payload_byte, r.payload_index, r.payload_valid, r.last);
  endfunction

  task automatic drop_partial();
    fill      = 0;
    esc_armed = 1'b0;
    framing   = 1'b0;
    crc_run   = 8'h00;
    crc_prev  = 8'h00;
  endtask

  function automatic bit frame_passes();
    int unsigned len;
    int unsigned lim;
    if (esc_armed || fill < FRAME_OVERHEAD || fill > RAW) return 1'b0;
    if (frame_mem[0] != version_cfg) return 1'b0;
    len = frame_mem[2];
    lim = (max_pay_cfg < PAY) ? max_pay_cfg : PAY;
    if (len > lim || fill != FRAME_OVERHEAD + len) return 1'b0;
    return crc_prev == frame_mem[fill - 1];
  endfunction

  task automatic owe_reject();
    out_t r;
    r        = '0;
    r.status = 1'b1;
    r.last   = 1'b1;
    owed_q.push_back(r);
  endtask

  // A good frame becomes one beat per payload byte, or one beat if empty.
  task automatic owe_frame();
    out_t        r;
    int unsigned len;
    int unsigned runs;
    len  = frame_mem[2];
    runs = (len == 0) ? 1 : len;
    for (int k = 0; k < runs; k++) begin
      r.status        = 1'b0;
      r.command       = frame_mem[1];
      r.length        = 5'(len);
      r.sequence_res  = {frame_mem[4], frame_mem[3]};
      r.session       = {frame_mem[8], frame_mem[7], frame_mem[6], frame_mem[5]};
      r.payload_byte  = (len != 0) ? frame_mem[HDR_LEN + k] : 8'h00;
      r.payload_index = (len != 0) ? 4'(k) : 4'd0;
      r.payload_valid = (len != 0);
      r.last          = (k == runs - 1);
      owed_q.push_back(r);
    end
  endtask

  task automatic take_byte(input in_t beat);
    logic [7:0] b;
    b = beat.rx_byte;
    if (framing && (beat.now_ms - last_ms) > timeout_cfg) drop_partial();
    last_ms = beat.now_ms;
    if (b == FLAG_BYTE) begin
      if (framing && fill != 0) begin
        if (frame_passes()) owe_frame();
        else owe_reject();
      end
      fill      = 0;
      esc_armed = 1'b0;
      crc_run   = 8'h00;
      crc_prev  = 8'h00;
      framing   = 1'b1;
      return;
    end
    if (!framing) return;
    if (esc_armed) begin
      if (b != ESC_LO && b != ESC_HI) begin
        drop_partial();
        owe_reject();
        return;
      end
      b         = b ^ ESC_XOR;
      esc_armed = 1'b0;
    end else if (b == ESC_BYTE) begin
      esc_armed = 1'b1;
      return;
    end
    if (fill >= RAW) begin
      drop_partial();
      owe_reject();
      return;
    end
    frame_mem[fill] = b;
    fill++;
    crc_prev = crc_run;
    crc_run  = crc_fold(crc_run, b);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      drop_partial();
      last_ms     = 32'h0;
      timeout_cfg = TIMEOUT_RST;
      version_cfg = VERSION_RST;
      max_pay_cfg = MAXPAY_RST;
      owed_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_TIMEOUT: timeout_cfg = pwdata[15:0];
          REG_VERSION: version_cfg = pwdata[7:0];
          REG_MAXPAY:  max_pay_cfg = pwdata[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_byte(in_data);
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result beat with none expected: %s", $time, beat_text(out_data));
        end else begin
          want = owed_q.pop_front();
          if (out_data !== want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: result beat mismatch\n  expected %s\n  actual   %s",
                       $time, beat_text(want), beat_text(out_data));
          end
        end
      end
    end
    mismatches <= err_cnt;
    beats_owed <= owed_q.size();
  end

endmodule

[test/byte_stuffed_frame_receiver_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_tb
// Feeds the frame receiver with stuffed wire bytes: a short hand-built
// sequence first, then random frames, good and broken, under several register
// settings. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver_tb;
  import bsfr_pkg::*;

  // Roughly 330 wire bytes in all: the opening sequence, then six register
  // settings, each running until the frame in progress at its quota closes.
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS  = 40;
  // Length of the one long output hold-off.
  localparam int unsigned HOLD_CYCLES  = 300;
  // A short drain covers everything still in flight once nothing is owed.
  localparam int unsigned DRAIN_CYCLES = 16;
  // Byte address past the last register.
  localparam logic [3:0]  ADDR_UNMAPPED = 4'hC;

  // Register settings per phase. Phase 0 runs on the reset values and the
  // last phase draws its own random values.
  localparam logic [15:0] TMO_TAB [NUM_PHASES] = '{16'd100, 16'd0, 16'd65535, 16'd3,
                                                  16'd200, 16'd0};
  localparam logic [7:0]  VER_TAB [NUM_PHASES] = '{8'h01, 8'hFF, 8'h00, 8'h7E, 8'h7D, 8'h00};
  localparam logic [4:0]  MAX_TAB [NUM_PHASES] = '{5'd16, 5'd0, 5'd16, 5'd31, 5'd5, 5'd0};

  typedef enum {
    FR_GOOD,
    FR_BAD_VER,
    FR_BAD_LEN,
    FR_BAD_SIZE,
    FR_BAD_CRC,
    FR_BAD_ESC,
    FR_OVERFLOW,
    FR_TIMEOUT,
    FR_OPEN_ESC
  } frame_kind_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned beats_owed;

  // Stimulus bookkeeping: the wire clock in milliseconds and the register
  // values last written, which shape the frames that are built.
  logic [31:0] clock_ms    = 32'hFFFF_FFF8;
  logic [15:0] cur_timeout = TIMEOUT_RST;
  logic [7:0]  cur_version = VERSION_RST;
  logic [4:0]  cur_max     = MAXPAY_RST;
  int unsigned items       = 0;

  // quiet turns off idling on both sides; hold_req asks for the long hold-off.
  logic        quiet       = 1'b0;
  logic        hold_req    = 1'b0;
  logic        hold_done   = 1'b0;

  always #4 clk = ~clk;

  byte_stuffed_frame_receiver DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  byte_stuffed_frame_receiver_checker frame_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .mismatches(mismatches),
    .beats_owed(beats_owed)
  );

  // Hard limit on the run, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // The result side stalls at random. Once, on request, it holds off for a
  // long stretch so that the block fills up and pushes back on its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 11);
      end
    end
  end

  // CRC-8, polynomial 0x07, used to build frames with a valid check byte.
  function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
    c = c ^ b;
    for (int i = 0; i < 8; i++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // Bytes that need stuffing or look like escape codes turn up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      2:       return ($urandom_range(1) != 0) ? ESC_LO : ESC_HI;
      default: return 8'($urandom);
    endcase
  endfunction

  // Any byte that may not follow an escape; a flag would close the frame.
  function automatic logic [7:0] odd_escape();
    logic [7:0] b;
    do b = 8'($urandom); while (b == ESC_LO || b == ESC_HI || b == FLAG_BYTE);
    return b;
  endfunction

  // A gap that never trips the timeout; now and then exactly at the limit.
  function automatic logic [31:0] calm_gap();
    if ($urandom_range(99) < 5) return 32'(cur_timeout);
    return $urandom_range(0, (cur_timeout < 3) ? cur_timeout : 3);
  endfunction

  function automatic frame_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return FR_GOOD;
    if (r < 65) return FR_BAD_VER;
    if (r < 70) return FR_BAD_LEN;
    if (r < 75) return FR_BAD_SIZE;
    if (r < 80) return FR_BAD_CRC;
    if (r < 85) return FR_BAD_ESC;
    if (r < 90) return FR_OVERFLOW;
    if (r < 95) return FR_TIMEOUT;
    return FR_OPEN_ESC;
  endfunction

  // Offers one beat and returns at the edge that accepts it. Valid stays high
  // into the next call unless that call decides to idle first.
  task automatic send_beat(input logic [7:0] b, input logic [31:0] gap);
    in_t beat;
    if (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    clock_ms     = clock_ms + gap;
    beat.rx_byte = b;
    beat.now_ms  = clock_ms;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    items++;
  endtask

  // One frame byte on the wire, escaped where it collides with a code byte.
  task automatic send_wire(input logic [7:0] b, input logic [31:0] gap);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      send_beat(ESC_BYTE, gap);
      send_beat(b ^ ESC_XOR, calm_gap());
    end else begin
      send_beat(b, gap);
    end
  endtask

  // Register write: the setup phase, then the access phase until pready.
  // psel stays up between back-to-back writes; the caller lowers it.
  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Upper bits are filled with junk to show that writes are masked.
  task automatic program_regs(input logic [15:0] tmo, input logic [7:0] ver,
                              input logic [4:0] maxp, input bit poke_unmapped);
    logic [31:0] junk;
    junk = $urandom;
    reg_write({REG_TIMEOUT, 2'b00}, {junk[31:16], tmo});
    reg_write({REG_VERSION, 2'b00}, {junk[31:8], ver});
    reg_write({REG_MAXPAY, 2'b00}, {junk[31:5], maxp});
    if (poke_unmapped) reg_write(ADDR_UNMAPPED, $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_timeout = tmo;
    cur_version = ver;
    cur_max     = maxp;
  endtask

  // Stops offering bytes and waits until every owed result beat has come
  // out, plus a short drain for bytes that cause no result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Builds one frame of the given kind from the current settings and sends
  // it between flags. Broken kinds spoil exactly one property of the frame.
  task automatic send_frame(input frame_kind_t kind);
    logic [7:0]  raw[$];
    logic [7:0]  crc;
    logic [31:0] late_gap;
    int unsigned len;
    int unsigned lim;
    int unsigned cut;
    lim = (cur_max < PAYLOAD_DEPTH_DEF) ? cur_max : PAYLOAD_DEPTH_DEF;
    case (kind)
      FR_BAD_LEN:  len = (lim < PAYLOAD_DEPTH_DEF) ? $urandom_range(lim + 1, 255)
                                                   : $urandom_range(PAYLOAD_DEPTH_DEF + 1, 255);
      FR_OVERFLOW: len = PAYLOAD_DEPTH_DEF;
      default:     len = ($urandom_range(3) == 0) ? lim : $urandom_range(0, lim);
    endcase
    raw.push_back((kind == FR_BAD_VER) ? cur_version ^ 8'($urandom_range(1, 255))
                                       : cur_version);
    raw.push_back(pick_byte());
    raw.push_back(8'(len));
    repeat (6) raw.push_back(pick_byte());
    for (int k = 0; k < len && k < PAYLOAD_DEPTH_DEF; k++) raw.push_back(pick_byte());
    // One byte too many or too few for the length field.
    if (kind == FR_BAD_SIZE) begin
      if ($urandom_range(1) != 0) raw.push_back(pick_byte());
      else void'(raw.pop_back());
    end
    crc = 8'h00;
    foreach (raw[i]) crc = crc8_next(crc, raw[i]);
    raw.push_back((kind == FR_BAD_CRC) ? crc ^ 8'($urandom_range(1, 255)) : crc);
    // A full frame plus extra bytes runs past the raw buffer.
    if (kind == FR_OVERFLOW) repeat ($urandom_range(1, 3)) raw.push_back(pick_byte());

    cut      = $urandom_range(0, raw.size() - 1);
    late_gap = 32'(cur_timeout) + 32'd1 +
               (($urandom_range(3) == 0) ? ($urandom & 32'h7FFF_FFFF) : $urandom_range(0, 500));

    // Most frames bring their own opening flag; the rest share the closing
    // flag of the frame before.
    if ($urandom_range(9) < 7) send_beat(FLAG_BYTE, calm_gap());
    for (int i = 0; i < raw.size(); i++) begin
      if (kind == FR_BAD_ESC && i == cut) begin
        send_beat(ESC_BYTE, calm_gap());
        send_beat(odd_escape(), calm_gap());
      end
      send_wire(raw[i], (kind == FR_TIMEOUT && i == cut) ? late_gap : calm_gap());
    end
    // An escape left hanging when the closing flag arrives.
    if (kind == FR_OPEN_ESC) send_beat(ESC_BYTE, calm_gap());
    send_beat(FLAG_BYTE, calm_gap());
  endtask

  initial begin
    logic [7:0]  hand[$];
    logic [7:0]  crc;
    int unsigned phase_end;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Hand-built opening sequence on the reset settings. The wire clock
    // starts just below its wrap point and crosses it here.
    send_beat(8'h5A, 1);          // data before any flag is ignored
    send_beat(FLAG_BYTE, 1);      // opens a frame
    send_beat(FLAG_BYTE, 1);      // empty frame: no result, stays open
    send_beat(ESC_BYTE, 1);
    send_beat(8'h00, 1);          // illegal escape: one reject beat
    send_beat(8'hFF, 1);          // ignored until the next flag
    send_beat(FLAG_BYTE, 1);
    // Good frame with an empty payload; command and sequence need escapes.
    hand = {8'h01, FLAG_BYTE, 8'h00, ESC_BYTE, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01};
    crc  = 8'h00;
    foreach (hand[i]) crc = crc8_next(crc, hand[i]);
    hand.push_back(crc);
    foreach (hand[i]) send_wire(hand[i], 1);
    send_beat(FLAG_BYTE, 1);      // closes it and opens the next frame
    send_beat(8'h01, 1);
    send_beat(8'h02, 32'(TIMEOUT_RST) + 1);  // silence drops the partial frame
    send_beat(FLAG_BYTE, 1);
    send_beat(ESC_BYTE, 1);
    send_beat(FLAG_BYTE, 1);      // nothing stored yet, so no result

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        settle();
        if (p == NUM_PHASES - 1)
          program_regs(16'($urandom_range(0, 300)), 8'($urandom), 5'($urandom_range(0, 31)), 1'b0);
        else
          program_regs(TMO_TAB[p], VER_TAB[p], MAX_TAB[p], p == 4);
      end
      // The long hold-off falls on a phase that allows full-length frames and one
      // phase runs without any idling on either side.
      if (p == 2) hold_req <= 1'b1;
      quiet <= (p == 3);
      phase_end = items + PHASE_ITEMS;
      while (items < phase_end) begin
        // Occasional line noise between frames, some of it after a long
        // silence with a random timestamp jump.
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(1, 3))
            send_beat(8'($urandom), ($urandom_range(1) != 0) ? calm_gap() : $urandom);
        send_frame(pick_kind());
      end
    end

    settle();
    if (mismatches == 0 && beats_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
